// ===== rtl/dkfl_pkg.sv =====
package dkfl_pkg;

    localparam int unsigned KEY_W    = 23;
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MD_W     = 7;
    localparam int unsigned VALUE_W  = 40;
    localparam int unsigned RATE_W   = 39;
    localparam int unsigned AMT_W    = 26;
    localparam int unsigned PROD_W   = 50;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_YEAR     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMOUNT_LIMIT = 2'd1;

    localparam logic [YEAR_W-1:0] MIN_YEAR_RST     = 14'd2000;
    localparam logic [AMT_W-1:0]  AMOUNT_LIMIT_RST = 26'd65536000;
    localparam logic [MD_W-1:0]   MONTH_MAX        = 7'd12;
    localparam logic [MD_W-1:0]   DAY_MAX          = 7'd31;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_DATE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NEGATIVE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_EARLIER = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SRCH,
        S_SCMP,
        S_PRD,
        S_PCMP,
        S_SHCHK,
        S_SHRD,
        S_SHWR,
        S_INS,
        S_RRD,
        S_MLO,
        S_MHI,
        S_SUM,
        S_DONE
    } state_t;

endpackage

// ===== rtl/date_keyed_floor_lookup_table_core.sv =====
// Sorted date-keyed rate table with predecessor lookup. Keys are packed as
// year, month, day and kept in ascending order in an on-chip memory of
// TABLE_DEPTH words. One word is handled at a time; s_ready is high only
// when the sequencer is idle, while a finished result may still sit in the
// output register. Every access goes through the single registered read port
// of the table, so a binary search step takes a read state and a compare
// state. A query uses one shared 26x23 multiplier twice for the product.
// An insert of a new date moves every later entry up by one, with a check,
// a read and a write state per moved entry, on top of the search. Invalid
// words return a status without touching the table. A result that is not
// taken holds the sequencer in its last state until the output register
// frees up. The table needs no clearing after reset: only entries below the
// fill count are ever used. Configuration writes are taken on any cycle
// cfg_we is high.
module date_keyed_floor_lookup_table_core
    import dkfl_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [AMT_W-1:0]      cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  logic [YEAR_W-1:0]     s_date_year,
    input  logic [MD_W-1:0]       s_date_month,
    input  logic [MD_W-1:0]       s_date_day,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [RATE_W-1:0]     m_rate_found,
    output logic [PROD_W-1:0]     m_product
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = AW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // table storage, no reset
    logic [KEY_W-1:0]  key_mem  [TABLE_DEPTH];
    logic [RATE_W-1:0] rate_mem [TABLE_DEPTH];

    state_t state_reg, state_next;

    logic [YEAR_W-1:0]   min_year_reg;
    logic [AMT_W-1:0]    amount_limit_reg;

    // captured word
    logic                cmd_reg;
    logic [YEAR_W-1:0]   year_reg;
    logic [MD_W-1:0]     month_reg;
    logic [MD_W-1:0]     day_reg;
    logic [VALUE_W-1:0]  value_reg;

    // sequencer datapath
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       lo_reg, lo_next;
    logic [CW-1:0]       hi_reg, hi_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                match_reg, match_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [48:0]         mul_reg, mul_next;
    logic [AMT_W-1:0]    acc_reg, acc_next;

    // memory port
    logic [AW-1:0]       rd_addr;
    logic [KEY_W-1:0]    key_rd_reg;
    logic [RATE_W-1:0]   rate_rd_reg;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [KEY_W-1:0]    wr_key;
    logic [RATE_W-1:0]   wr_rate;

    // output register
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [RATE_W-1:0]   m_rate_reg;
    logic [PROD_W-1:0]   m_product_reg;

    logic [KEY_W-1:0]    key;
    logic                date_bad;
    logic [CW-1:0]       mid;
    logic [22:0]         mul_b;
    logic                out_free;

    assign key = {year_reg, month_reg[3:0], day_reg[4:0]};
    assign date_bad = (year_reg < min_year_reg) || (month_reg == '0)
                   || (month_reg > MONTH_MAX) || (day_reg == '0) || (day_reg > DAY_MAX);
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_rate_found = m_rate_reg;
    assign m_product    = m_product_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_year_reg     <= MIN_YEAR_RST;
            amount_limit_reg <= AMOUNT_LIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MIN_YEAR:     min_year_reg     <= cfg_wdata[YEAR_W-1:0];
                REG_AMOUNT_LIMIT: amount_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_CHECK;
            S_CHECK: begin
                if (date_bad || value_reg[VALUE_W-1]) begin
                    state_next = S_DONE;
                end else if (cmd_reg == CMD_QUERY &&
                             value_reg[VALUE_W-2:0] > {13'd0, amount_limit_reg}) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_SRCH;
                end
            end
            S_SRCH:  state_next = (lo_reg < hi_reg) ? S_SCMP : S_PRD;
            S_SCMP:  state_next = S_SRCH;
            S_PRD:   state_next = S_PCMP;
            S_PCMP: begin
                if (cmd_reg == CMD_INSERT) begin
                    if (lo_reg < count_reg && key_rd_reg == key) state_next = S_INS;
                    else if (count_reg == DEPTH_C)               state_next = S_DONE;
                    else                                         state_next = S_SHCHK;
                end else begin
                    if (lo_reg < count_reg && key_rd_reg == key) state_next = S_RRD;
                    else if (lo_reg == '0)                       state_next = S_DONE;
                    else                                         state_next = S_RRD;
                end
            end
            S_SHCHK: state_next = (idx_reg > lo_reg) ? S_SHRD : S_INS;
            S_SHRD:  state_next = S_SHWR;
            S_SHWR:  state_next = S_SHCHK;
            S_INS:   state_next = S_DONE;
            S_RRD:   state_next = S_MLO;
            S_MLO:   state_next = S_MHI;
            S_MHI:   state_next = S_SUM;
            S_SUM:   state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        match_next = match_reg;
        st_next    = st_reg;
        mul_next   = mul_reg;
        acc_next   = acc_reg;
        rd_addr    = idx_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = idx_reg[AW-1:0];
        wr_key     = key_rd_reg;
        wr_rate    = rate_rd_reg;
        mul_b      = '0;
        case (state_reg)
            S_CHECK: begin
                lo_next    = '0;
                hi_next    = count_reg;
                match_next = 1'b0;
                st_next    = ST_OK;
                mul_next   = '0;
                acc_next   = '0;
                if (date_bad)                  st_next = ST_BAD_DATE;
                else if (value_reg[VALUE_W-1]) st_next = ST_NEGATIVE;
                else if (cmd_reg == CMD_QUERY &&
                         value_reg[VALUE_W-2:0] > {13'd0, amount_limit_reg})
                    st_next = ST_TOO_LARGE;
            end
            S_SRCH: begin
                rd_addr  = mid[AW-1:0];
                idx_next = mid;
            end
            S_SCMP: begin
                if (key_rd_reg < key) lo_next = idx_reg + CW'(1);
                else                  hi_next = idx_reg;
            end
            S_PRD:  rd_addr = lo_reg[AW-1:0];
            S_PCMP: begin
                match_next = (lo_reg < count_reg) && (key_rd_reg == key);
                if (cmd_reg == CMD_INSERT) begin
                    idx_next = count_reg;
                    if (!match_next && count_reg == DEPTH_C) st_next = ST_FULL;
                end else begin
                    if (match_next)          idx_next = lo_reg;
                    else if (lo_reg == '0)   st_next  = ST_NO_EARLIER;
                    else                     idx_next = lo_reg - CW'(1);
                end
            end
            S_SHRD: rd_addr = AW'(idx_reg - CW'(1));
            S_SHWR: begin
                wr_en    = 1'b1;
                idx_next = idx_reg - CW'(1);
            end
            S_INS: begin
                wr_en   = 1'b1;
                wr_addr = lo_reg[AW-1:0];
                wr_key  = key;
                wr_rate = value_reg[RATE_W-1:0];
                if (!match_reg) count_next = count_reg + CW'(1);
            end
            S_RRD: rd_addr = idx_reg[AW-1:0];
            S_MLO: begin
                mul_b    = {7'd0, rate_rd_reg[15:0]};
                mul_next = value_reg[AMT_W-1:0] * mul_b;
            end
            S_MHI: begin
                mul_b    = rate_rd_reg[RATE_W-1:16];
                acc_next = mul_reg[41:16];
                mul_next = value_reg[AMT_W-1:0] * mul_b;
            end
            // sum stays below 2^49: amount < 2^26, upper rate < 2^23
            S_SUM: mul_next = mul_reg + 49'(acc_reg);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        key_rd_reg  <= key_mem[rd_addr];
        rate_rd_reg <= rate_mem[rd_addr];
        if (wr_en) begin
            key_mem[wr_addr]  <= wr_key;
            rate_mem[wr_addr] <= wr_rate;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        idx_reg   <= idx_next;
        match_reg <= match_next;
        st_reg    <= st_next;
        mul_reg   <= mul_next;
        acc_reg   <= acc_next;
        if (s_valid && s_ready) begin
            cmd_reg   <= s_cmd;
            year_reg  <= s_date_year;
            month_reg <= s_date_month;
            day_reg   <= s_date_day;
            value_reg <= s_value;
        end
        // output fields only move once the previous word has left
        if (state_reg == S_DONE && out_free) begin
            m_status_reg <= st_reg;
            if (st_reg == ST_OK && cmd_reg == CMD_QUERY) begin
                m_rate_reg    <= rate_rd_reg;
                m_product_reg <= PROD_W'(mul_reg);
            end else begin
                m_rate_reg    <= '0;
                m_product_reg <= '0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("fill count above table depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CW'(1) && $past(state_reg) == S_INS))
        else $error("fill count changed outside an insert");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_rate_found == '0 && m_product == '0))
        else $error("failed word carries nonzero data");

    a_accept_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_CHECK))
        else $error("accepted word not checked next cycle");
`endif

endmodule

// ===== dv/dkfl_rate_checker.sv =====
module dkfl_rate_checker
    import dkfl_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [AMT_W-1:0]          cfg_wdata,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic                      s_cmd,
    input  logic [YEAR_W-1:0]         s_date_year,
    input  logic [MD_W-1:0]           s_date_month,
    input  logic [MD_W-1:0]           s_date_day,
    input  logic signed [VALUE_W-1:0] s_value,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [STATUS_W-1:0]       m_status,
    input  logic [RATE_W-1:0]         m_rate_found,
    input  logic [PROD_W-1:0]         m_product,
    output int                        fail_count,
    output int                        words_due,
    output int                        table_fill
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RATE_W-1:0]   rate;
        logic [PROD_W-1:0]   prod;
    } rate_reply_t;

    logic [KEY_W-1:0]  key_mem [TABLE_DEPTH];
    logic [RATE_W-1:0] rate_mem[TABLE_DEPTH];
    int unsigned       entries;
    logic [YEAR_W-1:0] year_floor;
    logic [AMT_W-1:0]  amt_limit;
    rate_reply_t       reply_due[$];

    initial fail_count = 0;
    assign words_due  = reply_due.size();
    assign table_fill = entries;

    function automatic rate_reply_t lookup_rate(logic cmd, logic [YEAR_W-1:0] y,
                                                logic [MD_W-1:0] mo, logic [MD_W-1:0] dy,
                                                logic [VALUE_W-1:0] v);
        rate_reply_t      r;
        logic [KEY_W-1:0] key;
        int unsigned      lo, hi, mid, idx;
        logic [79:0]      full;
        r = '0;
        if (y < year_floor || mo < 1 || mo > MONTH_MAX || dy < 1 || dy > DAY_MAX) begin
            r.status = ST_BAD_DATE;
            return r;
        end
        if (v[VALUE_W-1]) begin
            r.status = ST_NEGATIVE;
            return r;
        end
        key = {y, mo[3:0], dy[4:0]};
        lo = 0;
        hi = entries;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (key_mem[mid] < key) lo = mid + 1;
            else hi = mid;
        end
        if (cmd == CMD_INSERT) begin
            if (lo < entries && key_mem[lo] == key) begin
                rate_mem[lo] = v[RATE_W-1:0];
            end else if (entries >= TABLE_DEPTH) begin
                r.status = ST_FULL;
                return r;
            end else begin
                for (int i = entries; i > lo; i--) begin
                    key_mem[i]  = key_mem[i-1];
                    rate_mem[i] = rate_mem[i-1];
                end
                key_mem[lo]  = key;
                rate_mem[lo] = v[RATE_W-1:0];
                entries++;
            end
            r.status = ST_OK;
            return r;
        end
        if (v > {14'd0, amt_limit}) begin
            r.status = ST_TOO_LARGE;
            return r;
        end
        if (lo < entries && key_mem[lo] == key) idx = lo;
        else if (lo == 0) begin
            r.status = ST_NO_EARLIER;
            return r;
        end else idx = lo - 1;
        full     = 80'(v) * 80'(rate_mem[idx]);
        r.status = ST_OK;
        r.rate   = rate_mem[idx];
        r.prod   = full[16 +: PROD_W];
        return r;
    endfunction

    always @(posedge aclk) begin
        rate_reply_t exp_r;
        if (!aresetn) begin
            entries    = 0;
            year_floor = MIN_YEAR_RST;
            amt_limit  = AMOUNT_LIMIT_RST;
            reply_due.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_MIN_YEAR) year_floor = cfg_wdata[YEAR_W-1:0];
                else if (cfg_index == REG_AMOUNT_LIMIT) amt_limit = cfg_wdata;
            end
            if (m_valid && m_ready) begin
                if (reply_due.size() == 0) begin
                    $error("unexpected result word: status %0d", m_status);
                    fail_count++;
                end else begin
                    exp_r = reply_due.pop_front();
                    if (m_status !== exp_r.status) begin
                        $error("status: expected %0d got %0d", exp_r.status, m_status);
                        fail_count++;
                    end
                    if (m_rate_found !== exp_r.rate) begin
                        $error("rate_found: expected %0h got %0h", exp_r.rate, m_rate_found);
                        fail_count++;
                    end
                    if (m_product !== exp_r.prod) begin
                        $error("product: expected %0h got %0h", exp_r.prod, m_product);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                reply_due.push_back(lookup_rate(s_cmd, s_date_year, s_date_month,
                                                s_date_day, s_value));
        end
    end

endmodule

// ===== dv/tb_date_keyed_floor_lookup_table_core.sv =====
module tb_date_keyed_floor_lookup_table_core;
    import dkfl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH = 1024;
    localparam logic [AMT_W-1:0] AMT_MAX = '1;

    // clock, reset and every block input start at a known value
    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [AMT_W-1:0]          cfg_wdata = '0;
    logic                      s_valid   = 1'b0;
    logic                      s_cmd     = 1'b0;
    logic [YEAR_W-1:0]         s_date_year  = '0;
    logic [MD_W-1:0]           s_date_month = '0;
    logic [MD_W-1:0]           s_date_day   = '0;
    logic signed [VALUE_W-1:0] s_value   = '0;
    logic                      m_ready   = 1'b0;
    logic                      s_ready, m_valid;
    logic [STATUS_W-1:0]       m_status;
    logic [RATE_W-1:0]         m_rate_found;
    logic [PROD_W-1:0]         m_product;
    int                        fail_count, words_due, table_fill;

    // tb-side copy of the settings, only used to aim stimulus
    logic [YEAR_W-1:0] cur_floor = MIN_YEAR_RST;
    logic [AMT_W-1:0]  cur_limit = AMOUNT_LIMIT_RST;
    int idle_pct  = 0;   // sender idle, percent of cycles
    int stall_pct = 0;   // receiver stall, percent of cycles
    int hold_len  = 0;   // long receiver hold-off, in cycles

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    date_keyed_floor_lookup_table_core #(.TABLE_DEPTH(DEPTH)) u_top (.*);

    dkfl_rate_checker #(.TABLE_DEPTH(DEPTH)) u_chk (.*);

    // receiver: random stall, or a counted hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_len > 0) begin
            m_ready  <= 1'b0;
            hold_len <= hold_len - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // run limit
    initial begin
        #200_000_000;
        $display("status: fail");
        $finish;
    end

    // offer one word; valid stays high across back-to-back words
    task automatic send_word(logic cmd, logic [YEAR_W-1:0] y, logic [MD_W-1:0] mo,
                             logic [MD_W-1:0] dy, logic [VALUE_W-1:0] v);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_date_year  <= y;
        s_date_month <= mo;
        s_date_day   <= dy;
        s_value      <= v;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid and wait until every word has come back, plus some slack
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_due != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [AMT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic set_regs(logic [YEAR_W-1:0] yr, logic [AMT_W-1:0] lim);
        drain();
        // upper write-data bits are junk for the year register
        cfg_put(REG_MIN_YEAR, (AMT_W'($urandom) & ~AMT_W'(14'h3fff)) | AMT_W'(yr));
        cfg_put(REG_AMOUNT_LIMIT, lim);
        cfg_we    <= 1'b0;
        cur_floor  = yr;
        cur_limit  = lim;
    endtask

    function automatic logic [VALUE_W-1:0] rand40();
        return VALUE_W'({$urandom, $urandom});
    endfunction

    // one random word: mostly well-formed inserts and queries near stored dates
    task automatic rand_word();
        logic [YEAR_W-1:0]  y;
        logic [MD_W-1:0]    mo, dy;
        logic [VALUE_W-1:0] v;
        logic               cmd;
        int                 pick, vp;
        pick = $urandom_range(0, 99);
        y  = (cur_floor >= 14'd9999) ? 14'd9999 : cur_floor + YEAR_W'($urandom_range(0, 1));
        mo = MD_W'($urandom_range(1, 12));
        dy = ($urandom_range(0, 3) == 0) ? MD_W'($urandom_range(1, 31))
                                         : MD_W'(1 + 4 * $urandom_range(0, 7));
        vp = $urandom_range(0, 99);
        if (pick < 45) begin
            cmd = CMD_INSERT;
            if (vp < 8) v = rand40() | (40'd1 << 39);
            else if (vp < 40) v = VALUE_W'($urandom_range(0, 1 << 20));
            else v = rand40() & {1'b0, {39{1'b1}}};
        end else if (pick < 88) begin
            cmd = CMD_QUERY;
            if (vp < 70) v = {14'd0, AMT_W'($urandom)} % ({14'd0, cur_limit} + 40'd1);
            else if (vp < 80) v = {14'd0, cur_limit} + VALUE_W'($urandom_range(1, 3));
            else if (vp < 85) v = {14'd0, cur_limit};
            else if (vp < 92) v = rand40() | (40'd1 << 39);
            else v = rand40();
        end else begin
            // noise: anything the fields can carry
            cmd = 1'($urandom_range(0, 1));
            y   = YEAR_W'($urandom_range(0, 9999));
            mo  = MD_W'($urandom_range(0, 99));
            dy  = MD_W'($urandom_range(0, 99));
            v   = rand40();
        end
        send_word(cmd, y, mo, dy, v);
    endtask

    task automatic rand_phase(int n, int idle, int stall);
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            rand_word();
            if (i == n / 2 && $urandom_range(0, 1)) drain();
        end
    endtask

    initial begin
        logic [YEAR_W-1:0] fy;
        logic [MD_W-1:0]   fm, fd;
        int                k;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words at reset settings
        send_word(CMD_QUERY,  14'd2020, 7'd6,  7'd15, 40'd65536);   // empty table
        send_word(CMD_INSERT, 14'd1999, 7'd1,  7'd1,  40'd1);       // year below floor
        send_word(CMD_INSERT, 14'd2000, 7'd0,  7'd1,  40'd1);       // month zero
        send_word(CMD_QUERY,  14'd2000, 7'd13, 7'd1,  40'd1);       // month too big
        send_word(CMD_INSERT, 14'd2000, 7'd1,  7'd0,  40'd1);       // day zero
        send_word(CMD_QUERY,  14'd2000, 7'd1,  7'd32, 40'd1);       // day too big
        send_word(CMD_QUERY,  14'd0,    7'd99, 7'd99, '1);          // bad date beats negative
        send_word(CMD_INSERT, 14'd2010, 7'd5,  7'd10, '1);          // negative rate
        send_word(CMD_QUERY,  14'd2010, 7'd5,  7'd10, 40'd1 << 39); // negative amount
        send_word(CMD_INSERT, 14'd2010, 7'd5,  7'd10, 40'h7f_ffff_ffff); // largest rate
        send_word(CMD_INSERT, 14'd2000, 7'd1,  7'd1,  40'd0);       // earliest date, zero
        send_word(CMD_INSERT, 14'd9999, 7'd12, 7'd31, 40'd131072);  // latest date
        send_word(CMD_QUERY,  14'd2010, 7'd5,  7'd10, {14'd0, AMOUNT_LIMIT_RST});
        send_word(CMD_QUERY,  14'd2010, 7'd5,  7'd10, {14'd0, AMOUNT_LIMIT_RST} + 40'd1);
        send_word(CMD_QUERY,  14'd2012, 7'd1,  7'd1,  40'd100000);  // between dates
        send_word(CMD_QUERY,  14'd2000, 7'd1,  7'd1,  40'd65536);   // exact earliest
        send_word(CMD_INSERT, 14'd2010, 7'd5,  7'd10, 40'd98304);   // overwrite
        send_word(CMD_QUERY,  14'd9999, 7'd12, 7'd31, 40'd0);       // zero amount
        send_word(CMD_QUERY,  14'd9999, 7'd12, 7'd31, 40'hff_ffff_ffff);
        send_word(CMD_INSERT, 14'd2005, 7'd7,  7'd4,  40'd7);

        // random phases over several settings, extremes among them
        rand_phase(200, 0, 0);

        set_regs(14'd0, 26'd0);
        send_word(CMD_QUERY, 14'd0, 7'd1, 7'd1, 40'd0);             // limit zero, amount zero
        rand_phase(250, 88, 0);

        set_regs(14'd9999, AMT_MAX);
        hold_len = 400;           // receiver blocks, sender keeps pushing
        rand_phase(150, 0, 88);

        set_regs(YEAR_W'($urandom_range(1990, 2050)), AMT_W'($urandom));
        rand_phase(300, 28, 28);

        set_regs(14'd2000, AMT_MAX);
        cfg_put(2'd2, '1);        // writes past the register list
        cfg_put(2'd3, '0);
        cfg_we <= 1'b0;
        rand_phase(250, 0, 0);

        // fill with ascending new dates until the table is full
        set_regs(MIN_YEAR_RST, AMOUNT_LIMIT_RST);
        idle_pct  = 0;
        stall_pct = 0;
        k = 0;
        while (table_fill < DEPTH + 0 || k < 1) begin
            if (table_fill >= DEPTH) break;
            fy = YEAR_W'(9000 + k / 372);
            fm = MD_W'(1 + (k / 31) % 12);
            fd = MD_W'(1 + k % 31);
            send_word(CMD_INSERT, fy, fm, fd, 40'($urandom));
            drain();
            k++;
        end
        // full table: new dates dropped, existing ones still overwritten
        idle_pct  = 28;
        stall_pct = 28;
        for (int i = 0; i < 4; i++) begin
            fy = YEAR_W'(9000 + (k + i) / 372);
            fm = MD_W'(1 + ((k + i) / 31) % 12);
            fd = MD_W'(1 + (k + i) % 31);
            send_word(CMD_INSERT, fy, fm, fd, 40'd5);
        end
        send_word(CMD_INSERT, 14'd9000, 7'd1, 7'd1, 40'd262144);
        send_word(CMD_QUERY,  14'd9000, 7'd1, 7'd1, 40'd65536);
        send_word(CMD_QUERY,  14'd9000, 7'd1, 7'd15, 40'd65536);
        send_word(CMD_QUERY,  14'd2500, 7'd6, 7'd6, {14'd0, AMOUNT_LIMIT_RST});

        drain();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
